[hdl/ecg_adaptive_beat_detector_defines.svh]
// assertion macros for the ecg beat detector
`ifndef ECG_ADAPTIVE_BEAT_DETECTOR_DEFINES_SVH
`define ECG_ADAPTIVE_BEAT_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define ECG_ABD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ECG_ABD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ECG_ABD_ASSERT_SAME(label, ante, cons, msg)

`define ECG_ABD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hdl/ecg_abd_pkg.sv]
// shared types and constants for the ecg beat detector
package ecg_abd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int RR_W     = 16;
  localparam int NOISE_W  = 24;
  localparam int SIGNAL_W = 25;
  localparam int THR_W    = 24;

  localparam int CFG_ADDR_W = 2;

  // divide by 100 as multiply by ceil(2^39 / 100), exact for 32-bit numerators
  localparam int              WARM_NUM_W   = 32;
  localparam int              WARM_Q_W     = 26;
  localparam int              DIV100_SHIFT = 39;
  localparam logic [32:0]     DIV100_RECIP = 33'd5497558139;

  localparam logic [CFG_W-1:0] WARMUP_RESET     = 16'd1500;
  localparam logic [CFG_W-1:0] REFRACTORY_RESET = 16'd200;
  localparam logic [CFG_W-1:0] MIN_RR_RESET     = 16'd300;
  localparam logic [CFG_W-1:0] MAX_RR_RESET     = 16'd2000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WARMUP     = 2'd0,
    CFG_REFRACTORY = 2'd1,
    CFG_MIN_RR     = 2'd2,
    CFG_MAX_RR     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] warmup_ms;
    logic [CFG_W-1:0] refractory_ms;
    logic [CFG_W-1:0] min_rr_ms;
    logic [CFG_W-1:0] max_rr_ms;
  } cfg_t;

  typedef struct packed {
    logic             beat_found;
    logic             rr_valid;
    logic [RR_W-1:0]  rr_ms;
    logic [THR_W-1:0] threshold_level;
  } result_t;

endpackage

[hdl/ecg_adaptive_beat_detector.sv]
// ecg adaptive beat detector top level with stream ports and config registers
// throughput: one word per cycle while the output is not stalled, set by the level update loop
// an input register feeds the level logic, an output register holds the result
// reset: synchronous, clears window, levels, threshold, last beat time and valids
// reset also loads the config registers with their default values
module ecg_adaptive_beat_detector #(
  parameter int LEVEL_FRAC_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [47:0]                             s_tdata,  // sample[15:0], time_ms[47:16]
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [39:0]                             m_tdata,  // rr_ms[15:0], threshold_level[39:16]
  output logic [1:0]                              m_tuser,  // beat_found[0], rr_valid[1]
  input  logic                                    cfg_we,
  input  logic [ecg_abd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ecg_abd_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int SW = ecg_abd_pkg::SAMPLE_W;
  localparam int TW = ecg_abd_pkg::TIME_W;

  ecg_abd_pkg::cfg_t    cfg;
  ecg_abd_pkg::result_t res;
  ecg_abd_pkg::result_t out_res;

  logic                 in_valid;
  logic signed [SW-1:0] in_sample;
  logic [TW-1:0]        in_time;
  logic                 adv;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warmup_ms     <= ecg_abd_pkg::WARMUP_RESET;
      cfg.refractory_ms <= ecg_abd_pkg::REFRACTORY_RESET;
      cfg.min_rr_ms     <= ecg_abd_pkg::MIN_RR_RESET;
      cfg.max_rr_ms     <= ecg_abd_pkg::MAX_RR_RESET;
    end else if (cfg_we) begin
      unique case (ecg_abd_pkg::cfg_index_t'(cfg_addr))
        ecg_abd_pkg::CFG_WARMUP:     cfg.warmup_ms     <= cfg_wdata;
        ecg_abd_pkg::CFG_REFRACTORY: cfg.refractory_ms <= cfg_wdata;
        ecg_abd_pkg::CFG_MIN_RR:     cfg.min_rr_ms     <= cfg_wdata;
        ecg_abd_pkg::CFG_MAX_RR:     cfg.max_rr_ms     <= cfg_wdata;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SW-1:0];
      in_time   <= s_tdata[SW +: TW];
    end
  end

  ecg_abd_levels #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_levels (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .sample  (in_sample),
    .time_ms (in_time),
    .cfg     (cfg),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.threshold_level, out_res.rr_ms};
  assign m_tuser = {out_res.rr_valid, out_res.beat_found};

endmodule

[hdl/ecg_abd_div100.sv]
// constant divide by 100 through a reciprocal multiply
module ecg_abd_div100 (
  input  logic [ecg_abd_pkg::WARM_NUM_W-1:0] num,
  output logic [ecg_abd_pkg::WARM_Q_W-1:0]   quot
);

  localparam int PROD_W = ecg_abd_pkg::WARM_NUM_W + 33;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(num) * PROD_W'(ecg_abd_pkg::DIV100_RECIP);
  assign quot = prod[ecg_abd_pkg::DIV100_SHIFT +: ecg_abd_pkg::WARM_Q_W];

endmodule

[hdl/ecg_abd_levels.sv]
// sample window, noise and signal levels, threshold and beat classification
`include "ecg_adaptive_beat_detector_defines.svh"

module ecg_abd_levels #(
  parameter int LEVEL_FRAC_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic signed [ecg_abd_pkg::SAMPLE_W-1:0]   sample,
  input  logic [ecg_abd_pkg::TIME_W-1:0]            time_ms,
  input  ecg_abd_pkg::cfg_t                         cfg,
  output ecg_abd_pkg::result_t                      res
);

  localparam int SW    = ecg_abd_pkg::SAMPLE_W;
  localparam int TW    = ecg_abd_pkg::TIME_W;
  localparam int NW    = ecg_abd_pkg::NOISE_W;
  localparam int GW    = ecg_abd_pkg::SIGNAL_W;
  localparam int HW    = ecg_abd_pkg::THR_W;
  localparam int RW    = ecg_abd_pkg::RR_W;
  localparam int ACC_W = 34;
  localparam int LVW   = GW + 1;

  // the oldest sample of the window is middle_sample before the shift
  logic signed [SW-1:0] newest_sample;
  logic signed [SW-1:0] middle_sample;
  logic [NW-1:0]        noise_level;
  logic [GW-1:0]        signal_level;
  logic [HW-1:0]        threshold_reg;
  logic [TW-1:0]        last_beat_time;

  logic [NW-1:0] noise_level_next;
  logic [GW-1:0] signal_level_next;
  logic [HW-1:0] threshold_reg_next;
  logic [TW-1:0] last_beat_time_next;

  logic signed [SW-1:0] mid;
  logic [SW-1:0]        mid_mag;
  logic [ACC_W-1:0]     mq;
  logic                 local_max;
  logic                 warm;
  logic [TW-1:0]        d;
  logic                 past_ref;
  logic                 tested;
  logic                 is_beat;

  logic [ecg_abd_pkg::WARM_NUM_W-1:0] warm_num;
  logic [ecg_abd_pkg::WARM_Q_W-1:0]   warm_q;
  logic [NW-1:0]                      warm_noise;
  logic [LVW-1:0]                     warm_thr_sum;

  logic [ACC_W-1:0] sig_sum;
  logic [ACC_W-1:0] noise_sum;
  logic [ACC_W-1:0] sig_shr;
  logic [ACC_W-1:0] noise_shr;
  logic [GW-1:0]    sig_upd;
  logic [NW-1:0]    noise_upd;
  logic [NW-1:0]    noise_sel;
  logic [GW-1:0]    sig_sel;
  logic [LVW-1:0]   s_lvl;
  logic [LVW-1:0]   s_diff;
  logic [LVW-1:0]   adapt_sum;
  logic [HW-1:0]    adapt_thr;
  logic [RW-1:0]    rr_sat;
  logic             rr_ok;

  assign mid       = newest_sample;
  assign mid_mag   = mid[SW-1] ? SW'(-mid) : SW'(mid);
  assign mq        = ACC_W'(mid_mag) << LEVEL_FRAC_BITS;
  assign local_max = (newest_sample > middle_sample) && (newest_sample >= sample);
  assign warm      = time_ms < TW'(cfg.warmup_ms);

  // warm-up: (99 * noise + |m| + 50) / 100, rounded half up
  assign warm_num = ecg_abd_pkg::WARM_NUM_W'(noise_level) * ecg_abd_pkg::WARM_NUM_W'(99)
                  + ecg_abd_pkg::WARM_NUM_W'(mq) + ecg_abd_pkg::WARM_NUM_W'(50);

  ecg_abd_div100 u_div100 (
    .num  (warm_num),
    .quot (warm_q)
  );

  assign warm_noise   = (warm_q > ecg_abd_pkg::WARM_Q_W'({NW{1'b1}})) ? {NW{1'b1}}
                                                                       : NW'(warm_q);
  assign warm_thr_sum = LVW'(warm_noise) + LVW'(warm_noise >> 1);

  assign d        = time_ms - last_beat_time;
  assign past_ref = !d[TW-1] && (d > TW'(cfg.refractory_ms));
  assign tested   = local_max && past_ref;
  assign is_beat  = tested && !mid[SW-1] && (mid != '0)
                  && (mq > ACC_W'(threshold_reg));

  assign sig_sum   = ACC_W'(signal_level) * ACC_W'(7) + mq;
  assign noise_sum = ACC_W'(noise_level) * ACC_W'(7) + mq;
  assign sig_shr   = sig_sum >> 3;
  assign noise_shr = noise_sum >> 3;
  assign sig_upd   = (sig_shr > ACC_W'({GW{1'b1}})) ? {GW{1'b1}} : GW'(sig_shr);
  assign noise_upd = (noise_shr > ACC_W'({NW{1'b1}})) ? {NW{1'b1}} : NW'(noise_shr);

  assign sig_sel   = is_beat ? sig_upd : signal_level;
  assign noise_sel = is_beat ? noise_level : noise_upd;

  assign s_lvl     = (LVW'(sig_sel) > LVW'(noise_sel))
                   ? LVW'(sig_sel)
                   : LVW'(noise_sel) + (LVW'(1) << LEVEL_FRAC_BITS);
  assign s_diff    = s_lvl - LVW'(noise_sel);
  assign adapt_sum = LVW'(noise_sel) + (s_diff >> 2);
  assign adapt_thr = (adapt_sum > LVW'({HW{1'b1}})) ? {HW{1'b1}} : HW'(adapt_sum);

  assign rr_sat = (d > TW'({RW{1'b1}})) ? {RW{1'b1}} : RW'(d);
  assign rr_ok  = (d >= TW'(cfg.min_rr_ms)) && (d <= TW'(cfg.max_rr_ms));

  always_comb begin
    noise_level_next    = noise_level;
    signal_level_next   = signal_level;
    threshold_reg_next  = threshold_reg;
    last_beat_time_next = last_beat_time;
    res.beat_found      = 1'b0;
    res.rr_valid        = 1'b0;
    res.rr_ms           = '0;
    if (warm) begin
      noise_level_next   = warm_noise;
      threshold_reg_next = (warm_thr_sum > LVW'({HW{1'b1}})) ? {HW{1'b1}} : HW'(warm_thr_sum);
    end else if (tested) begin
      noise_level_next   = noise_sel;
      signal_level_next  = sig_sel;
      threshold_reg_next = adapt_thr;
      if (is_beat) begin
        last_beat_time_next = time_ms;
        res.beat_found      = 1'b1;
        res.rr_valid        = rr_ok;
        res.rr_ms           = rr_sat;
      end
    end
    res.threshold_level = threshold_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_sample  <= '0;
      middle_sample  <= '0;
      noise_level    <= '0;
      signal_level   <= '0;
      threshold_reg  <= '0;
      last_beat_time <= '0;
    end else if (en) begin
      newest_sample  <= sample;
      middle_sample  <= newest_sample;
      noise_level    <= noise_level_next;
      signal_level   <= signal_level_next;
      threshold_reg  <= threshold_reg_next;
      last_beat_time <= last_beat_time_next;
    end
  end

  `ECG_ABD_ASSERT_SAME(a_no_beat_in_warmup, en && warm, !res.beat_found, "beat during warm-up")
  `ECG_ABD_ASSERT_SAME(a_rr_needs_beat, en && res.rr_valid, res.beat_found, "rr without beat")
  `ECG_ABD_ASSERT_NEXT(a_beat_time, en && res.beat_found, last_beat_time == $past(time_ms), "beat time not kept")
  `ECG_ABD_ASSERT_NEXT(a_thr_hold, !en, $stable(threshold_reg) && $stable(noise_level), "levels moved while idle")

endmodule

[tb/ecg_adaptive_beat_detector_test.sv]
// stream-level test of the ecg beat detector against a cycle-free level and threshold predictor
`timescale 1ns / 100ps

module ecg_adaptive_beat_detector_test;

  localparam int     LVL_FRAC   = 8;
  localparam longint NOISE_TOP  = (longint'(1) << ecg_abd_pkg::NOISE_W) - 1;
  localparam longint SIGNAL_TOP = (longint'(1) << ecg_abd_pkg::SIGNAL_W) - 1;
  localparam longint THR_TOP    = (longint'(1) << ecg_abd_pkg::THR_W) - 1;
  localparam int     QUIET_LIMIT = 5000;
  localparam int     HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_CADENCE
  } rx_mode_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [47:0]                        s_tdata = '0;  // sample[15:0], time_ms[47:16]
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [39:0]                        m_tdata;       // rr_ms[15:0], threshold_level[39:16]
  logic [1:0]                         m_tuser;       // beat_found[0], rr_valid[1]
  logic                               cfg_we = 1'b0;
  logic [ecg_abd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [ecg_abd_pkg::CFG_W-1:0]      cfg_wdata = '0;

  ecg_adaptive_beat_detector #(.LEVEL_FRAC_BITS(LVL_FRAC)) DUT (.*);

  // predictor state
  logic [ecg_abd_pkg::CFG_W-1:0] warmup_limit     = ecg_abd_pkg::WARMUP_RESET;
  logic [ecg_abd_pkg::CFG_W-1:0] refractory_limit = ecg_abd_pkg::REFRACTORY_RESET;
  logic [ecg_abd_pkg::CFG_W-1:0] rr_floor         = ecg_abd_pkg::MIN_RR_RESET;
  logic [ecg_abd_pkg::CFG_W-1:0] rr_ceiling       = ecg_abd_pkg::MAX_RR_RESET;
  logic signed [15:0] win_new = '0;
  logic signed [15:0] win_mid = '0;
  logic signed [15:0] win_old = '0;
  longint             noise_lvl  = 0;
  longint             signal_lvl = 0;
  longint             thr_lvl    = 0;
  logic [31:0]        last_beat  = '0;

  logic [47:0]          samples_to_send[$];
  ecg_abd_pkg::result_t reports_due[$];
  int                   fail_count = 0;

  // stimulus generator state
  logic [31:0] now_ms = '0;
  int          until_beat = 0;
  int          peak_step = 0;
  int          peak_amp = 0;

  int burst_left = 0;
  int gap_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_cycle = 0;
  int       mode_left = 0;
  int       hold_left = 0;
  int       holds_done = 0;
  int       next_hold = 600;

  int quiet_cycles = 0;

  function automatic longint clip(longint v, longint top);
    return (v > top) ? top : v;
  endfunction

  function automatic ecg_abd_pkg::result_t classify_sample(logic signed [15:0] x,
                                                           logic [31:0] t);
    ecg_abd_pkg::result_t r;
    logic [31:0]          dt;
    longint               mag;
    longint               lift;
    logic                 peak;
    r = '0;
    win_old = win_mid;
    win_mid = win_new;
    win_new = x;
    peak = (win_mid > win_old) && (win_mid >= win_new);
    mag = win_mid;
    if (mag < 0) mag = -mag;
    mag = mag << LVL_FRAC;
    if (t < {16'd0, warmup_limit}) begin
      noise_lvl = clip((99 * noise_lvl + mag + 50) / 100, NOISE_TOP);
      thr_lvl = clip(noise_lvl + (noise_lvl >> 1), THR_TOP);
    end else begin
      dt = t - last_beat;
      if (peak && !dt[31] && dt > {16'd0, refractory_limit}) begin
        if (win_mid > 0 && mag > thr_lvl) begin
          r.beat_found = 1'b1;
          last_beat = t;
          r.rr_ms = (dt > 32'hFFFF) ? 16'hFFFF : dt[15:0];
          r.rr_valid = (dt >= rr_floor) && (dt <= rr_ceiling);
          signal_lvl = clip((7 * signal_lvl + mag) >> 3, SIGNAL_TOP);
        end else begin
          noise_lvl = clip((7 * noise_lvl + mag) >> 3, NOISE_TOP);
        end
        lift = (signal_lvl > noise_lvl) ? signal_lvl : noise_lvl + (longint'(1) << LVL_FRAC);
        thr_lvl = clip(noise_lvl + ((lift - noise_lvl) >> 2), THR_TOP);
      end
    end
    r.threshold_level = thr_lvl[ecg_abd_pkg::THR_W-1:0];
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        reports_due.push_back(classify_sample(s_tdata[15:0], s_tdata[47:16]));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0 || samples_to_send.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          s_tdata <= samples_to_send.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // result receiver with its own stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_done < 2 && s_tvalid && rx_cycle >= next_hold) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        next_hold = rx_cycle + 3000;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    ecg_abd_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (reports_due.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        if (m_tuser[0] !== want.beat_found) begin
          $error("beat_found expected %0d got %0d", want.beat_found, m_tuser[0]);
          fail_count++;
        end
        if (m_tuser[1] !== want.rr_valid) begin
          $error("rr_valid expected %0d got %0d", want.rr_valid, m_tuser[1]);
          fail_count++;
        end
        if (m_tdata[15:0] !== want.rr_ms) begin
          $error("rr_ms expected %0d got %0d", want.rr_ms, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tdata[39:16] !== want.threshold_level) begin
          $error("threshold_level expected %0d got %0d", want.threshold_level,
                 m_tdata[39:16]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(logic [15:0] v, logic [31:0] t);
    samples_to_send.push_back({t, v});
  endtask

  task automatic write_config(logic [15:0] w, logic [15:0] r, logic [15:0] lo,
                              logic [15:0] hi);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= ecg_abd_pkg::CFG_WARMUP;
    cfg_wdata <= w;
    warmup_limit = w;
    @(posedge clk);
    cfg_addr <= ecg_abd_pkg::CFG_REFRACTORY;
    cfg_wdata <= r;
    refractory_limit = r;
    @(posedge clk);
    cfg_addr <= ecg_abd_pkg::CFG_MIN_RR;
    cfg_wdata <= lo;
    rr_floor = lo;
    @(posedge clk);
    cfg_addr <= ecg_abd_pkg::CFG_MAX_RR;
    cfg_wdata <= hi;
    rr_ceiling = hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || s_tvalid || reports_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ecg-like words: noisy baseline with rise, peak and fall, plus stray noise words
  task automatic queue_ecg(int count);
    int          base;
    logic [15:0] v;
    for (int k = 0; k < count; k++) begin
      base = int'($urandom_range(0, 400)) - 200;
      if ($urandom_range(0, 9) == 0) begin
        v = 16'($urandom);
        if ($urandom_range(0, 2) == 0) now_ms = $urandom;
        else now_ms += $urandom_range(0, 60);
      end else begin
        now_ms += $urandom_range(4, 40);
        if (peak_step == 0 && until_beat == 0) begin
          peak_step = 3;
          until_beat = $urandom_range(6, 60);
          peak_amp = $urandom_range(300, 32767);
          if ($urandom_range(0, 11) == 0) peak_amp = -peak_amp;
        end else if (peak_step == 0) begin
          until_beat--;
        end
        case (peak_step)
          3: v = 16'(peak_amp / 2 + base);
          2: v = 16'(peak_amp);
          1: v = 16'(peak_amp / 4 + base);
          default: v = 16'(base);
        endcase
        if (peak_step != 0) peak_step--;
      end
      push_word(v, now_ms);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // warm-up with extreme samples
    push_word(16'sd32767, 32'd0);
    push_word(16'h8000, 32'd1);
    push_word(16'sd0, 32'd2);
    push_word(16'sd100, 32'd1499);
    // first beat, in range
    push_word(16'sd500, 32'd1600);
    push_word(16'sd20000, 32'd1604);
    push_word(16'sd300, 32'd1608);
    // negative peak counts as noise
    push_word(-16'sd300, 32'd1900);
    push_word(-16'sd100, 32'd1904);
    push_word(-16'sd200, 32'd1908);
    // not a peak, threshold held
    push_word(16'sd50, 32'd1912);
    // beat with interval too long
    push_word(16'sd0, 32'd5000);
    push_word(16'sd25000, 32'd5004);
    push_word(16'sd0, 32'd5008);
    // interval beyond 16 bits
    push_word(16'sd0, 32'd80000);
    push_word(16'sd25000, 32'd80004);
    push_word(16'sd0, 32'd80008);
    // timestamp behind last beat
    push_word(16'sd0, 32'd70000);
    push_word(16'sd25000, 32'd70004);
    push_word(16'sd0, 32'd70008);
    // inside refractory
    push_word(16'sd0, 32'd80100);
    push_word(16'sd30000, 32'd80104);
    push_word(16'sd0, 32'd80108);
    // flat top peak, then end of time range
    push_word(16'sd28000, 32'd81000);
    push_word(16'sd28000, 32'd81004);
    push_word(16'sd0, 32'hFFFF_FFFF);
    now_ms = 32'd90000;
    queue_ecg(200);
    wait_drained();

    write_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
    queue_ecg(270);
    wait_drained();

    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    now_ms = 32'd0;
    queue_ecg(150);
    wait_drained();

    // reversed rr limits with beats getting through
    write_config(16'd0, 16'd100, 16'd1500, 16'd400);
    queue_ecg(250);
    wait_drained();

    // defaults again, running across the timestamp wrap
    write_config(ecg_abd_pkg::WARMUP_RESET, ecg_abd_pkg::REFRACTORY_RESET,
                 ecg_abd_pkg::MIN_RR_RESET, ecg_abd_pkg::MAX_RR_RESET);
    now_ms = 32'hFFFF_F000;
    queue_ecg(300);
    wait_drained();

    write_config(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 400)),
                 16'($urandom_range(0, 800)), 16'($urandom_range(300, 3000)));
    now_ms = 32'd0;
    queue_ecg(300);
    wait_drained();

    write_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    queue_ecg(250);
    wait_drained();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
